// ===== rtl/rci_pkg.sv =====
// Shared widths, stage counts, status codes and sideband types for the
// ray against finite cylinder unit. No dependencies.
package rci_pkg;

	localparam int CRD_W    = 32;            // input field width
	localparam int CFG_W    = 31;            // radius and height registers
	localparam int TIME_W   = 64;            // Q24.40 times
	localparam int DISC_W   = 128;           // discriminant, Q.80
	localparam int ROOT_W   = DISC_W / 2;    // root, Q.40
	localparam int SQ_REM_W = ROOT_W + 2;    // root remainder
	localparam int NUM_W    = 97;            // dividend magnitude
	localparam int DEN_W    = 64;            // divisor
	localparam int QUO_W    = NUM_W;

	localparam int FRONT_ST = 6;
	localparam int SQ_ST    = ROOT_W;
	localparam int PREP_ST  = 2;
	localparam int DIV_ST   = NUM_W;
	localparam int CLIP_ST  = 4;
	localparam int LATENCY  = FRONT_ST + SQ_ST + PREP_ST + DIV_ST + CLIP_ST;

	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0] RADIUS_RST = 31'd16777216;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 31'd16777216;

	typedef enum logic [1:0] {
		ST_MISS  = 2'd0,
		ST_HIT   = 2'd1,
		ST_DEGEN = 2'd2
	} status_t;

	// travels with the discriminant through the root pipeline
	typedef struct packed {
		logic                    degen;
		logic                    miss;
		logic [DEN_W-1:0]        amag;
		logic signed [64:0]      b;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] vy;
	} side_a_t;

	// travels alongside the dividers
	typedef struct packed {
		logic                    degen;
		logic                    miss;
		logic                    neg_in;
		logic                    neg_out;
		logic                    neg_top;
		logic                    neg_bot;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] vy;
	} side_d_t;

	// signed 64-bit result from quotient magnitude and sign, saturated
	function automatic logic [TIME_W-1:0] sat_time(input logic [QUO_W-1:0] q, input logic neg);
		logic big;
		if (!neg) begin
			big = (q[QUO_W-1:TIME_W-1] != '0);
			return big ? {1'b0, {(TIME_W-1){1'b1}}} : q[TIME_W-1:0];
		end
		big = (q[QUO_W-1:TIME_W] != '0) || (q[TIME_W-1] && (q[TIME_W-2:0] != '0));
		return big ? {1'b1, {(TIME_W-1){1'b0}}} : TIME_W'(0) - q[TIME_W-1:0];
	endfunction

endpackage

// ===== rtl/ray_cylinder_intersection_unit.sv =====
// Top level of the ray against finite cylinder unit: configuration,
// stage glue between front end, root, dividers and back end. Depends on rci_pkg.
//
//  channel   signals                                   direction
//  request   start, busy, pos_x/y/z, vel_x/y/z         in (busy out)
//  result    done, status, time_in, time_out           out
//  config    wr_en, wr_index, wr_data                  in
//
// One request is taken in every cycle: busy is held low, so start alone
// accepts. Each result passes through the front end, the 64-stage square
// root, the prepare stages, the 97-stage dividers and the back end.
// Reset clears all valid bits and sets radius and height to 1.0.
// Results show for one cycle on done; the receiver cannot stall them.
module ray_cylinder_intersection_unit import rci_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [CRD_W-1:0]  pos_x,
	input  logic signed [CRD_W-1:0]  pos_y,
	input  logic signed [CRD_W-1:0]  pos_z,
	input  logic signed [CRD_W-1:0]  vel_x,
	input  logic signed [CRD_W-1:0]  vel_y,
	input  logic signed [CRD_W-1:0]  vel_z,
	input  logic                     wr_en,
	input  logic                     wr_index,
	input  logic [CFG_W-1:0]         wr_data,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [TIME_W-1:0] time_in,
	output logic signed [TIME_W-1:0] time_out
);

	logic [CFG_W-1:0] radius_q, height_q;

	logic              fr_valid;
	logic [DISC_W-1:0] fr_disc;
	side_a_t           fr_side;
	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	side_a_t           sq_side;

	// prepare stage 1: signed dividends
	logic               v_p1;
	logic signed [65:0] nin_p1, nout_p1;
	logic signed [64:0] top_p1, bot_p1;
	logic [DEN_W-1:0]   amag_p1;
	side_a_t            side_p1;
	logic signed [65:0] negb, rootx;
	logic signed [64:0] hw, y0;

	// prepare stage 2: magnitudes and signs
	logic               v_p2;
	logic [NUM_W-1:0]   nin_p2, nout_p2, top_p2, bot_p2;
	logic [DEN_W-1:0]   dt_p2, dp_p2;
	side_d_t            side_p2;
	logic signed [65:0] nin_abs, nout_abs;
	logic signed [64:0] top_abs, bot_abs;
	logic [CRD_W-1:0]   vmag;

	side_d_t          dside_q [DIV_ST];
	logic [DIV_ST-1:0] dvalid_q;
	logic [QUO_W-1:0] q_in, q_out, q_top, q_bot;
	status_t          st;

	assign busy = 1'b0;

	// configuration: out-of-list index cannot arise with a one-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			height_q <= HEIGHT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RADIUS: radius_q <= wr_data;
				REG_HEIGHT: height_q <= wr_data;
				default:    radius_q <= radius_q;
			endcase
		end
	end

	rci_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
		.radius(radius_q),
		.out_valid(fr_valid), .disc(fr_disc), .side(fr_side)
	);

	rci_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(fr_valid),
		.radicand(fr_disc), .in_side(fr_side),
		.out_valid(sq_valid), .root(sq_root), .out_side(sq_side)
	);

	// -B -/+ root, and the end-plane offsets +-h/2 - y in Q.56
	assign negb  = -(66'(sq_side.b));
	assign rootx = $signed({2'b00, sq_root});
	assign hw    = $signed({3'b000, height_q, 31'd0});
	assign y0    = $signed({sq_side.y[CRD_W-1], sq_side.y, 32'd0});

	assign nin_abs  = nin_p1[65] ? -nin_p1 : nin_p1;
	assign nout_abs = nout_p1[65] ? -nout_p1 : nout_p1;
	assign top_abs  = top_p1[64] ? -top_p1 : top_p1;
	assign bot_abs  = bot_p1[64] ? -bot_p1 : bot_p1;
	assign vmag     = side_p1.vy[CRD_W-1] ? CRD_W'(0) - $unsigned(side_p1.vy)
	                                       : $unsigned(side_p1.vy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1     <= 1'b0;
			v_p2     <= 1'b0;
			dvalid_q <= '0;
		end else begin
			v_p1     <= sq_valid;
			v_p2     <= v_p1;
			dvalid_q <= {dvalid_q[DIV_ST-2:0], v_p2};
		end
	end

	always_ff @(posedge clk) begin
		nin_p1  <= negb - rootx;
		nout_p1 <= negb + rootx;
		top_p1  <= hw - y0;
		bot_p1  <= -hw - y0;
		amag_p1 <= sq_side.amag;
		side_p1 <= sq_side;

		// shift the radial dividends up by 32 to land in Q.40
		nin_p2  <= {nin_abs[64:0], 32'd0};
		nout_p2 <= {nout_abs[64:0], 32'd0};
		top_p2  <= {33'd0, top_abs[63:0]};
		bot_p2  <= {33'd0, bot_abs[63:0]};
		dt_p2   <= amag_p1;
		dp_p2   <= {32'd0, vmag};
		side_p2.degen   <= side_p1.degen;
		side_p2.miss    <= side_p1.miss;
		side_p2.neg_in  <= nin_p1[65];
		side_p2.neg_out <= nout_p1[65];
		side_p2.neg_top <= top_p1[64] ^ side_p1.vy[CRD_W-1];
		side_p2.neg_bot <= bot_p1[64] ^ side_p1.vy[CRD_W-1];
		side_p2.y       <= side_p1.y;
		side_p2.vy      <= side_p1.vy;

		// hold the sideband level with the dividers
		for (int k = 0; k < DIV_ST; k++) begin
			if (k == 0) begin
				dside_q[k] <= side_p2;
			end else begin
				dside_q[k] <= dside_q[k-1];
			end
		end
	end

	rci_div u_div_in  (.clk(clk), .num(nin_p2),  .den(dt_p2), .quo(q_in));
	rci_div u_div_out (.clk(clk), .num(nout_p2), .den(dt_p2), .quo(q_out));
	rci_div u_div_top (.clk(clk), .num(top_p2),  .den(dp_p2), .quo(q_top));
	rci_div u_div_bot (.clk(clk), .num(bot_p2),  .den(dp_p2), .quo(q_bot));

	rci_clip u_clip (
		.clk(clk), .arst_n(arst_n),
		.in_valid(dvalid_q[DIV_ST-1]), .in_side(dside_q[DIV_ST-1]),
		.q_in(q_in), .q_out(q_out), .q_top(q_top), .q_bot(q_bot),
		.height(height_q),
		.done(done), .status(st), .time_in(time_in), .time_out(time_out)
	);

	assign status = st;

	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("request lost in the pipeline");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result with no matching request");

endmodule

// ===== rtl/rci_front.sv =====
// Front end: radial quadratic coefficients and the exact discriminant.
// Depends on rci_pkg.
module rci_front import rci_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [CRD_W-1:0] pos_x,
	input  logic signed [CRD_W-1:0] pos_y,
	input  logic signed [CRD_W-1:0] pos_z,
	input  logic signed [CRD_W-1:0] vel_x,
	input  logic signed [CRD_W-1:0] vel_y,
	input  logic signed [CRD_W-1:0] vel_z,
	input  logic [CFG_W-1:0]        radius,
	output logic                    out_valid,
	output logic [DISC_W-1:0]       disc,
	output side_a_t                 side
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [63:0] vxx_s1, vzz_s1, bx_s1, bz_s1, xx_s1, zz_s1;
	logic [2*CFG_W-1:0] rr_s1;
	logic [63:0] a_s2;
	logic signed [64:0] b_s2, c_s2;
	logic [63:0] amag_s3, bm_s3, cmag_s3;
	logic degen_s3, cneg_s3;
	logic signed [64:0] b_s3;
	logic [63:0] p00_s4, p01_s4, p11_s4, q00_s4, q01_s4, q10_s4, q11_s4;
	logic [63:0] amag_s4;
	logic degen_s4, cneg_s4;
	logic signed [64:0] b_s4;
	logic [DISC_W-1:0] bm2_s5, ac_s5, dsum, disc_s6;
	logic [63:0] amag_s5, amag_s6;
	logic degen_s5, cneg_s5, degen_s6, miss_s6;
	logic signed [64:0] b_s5, b_s6;
	logic signed [CRD_W-1:0] y_s1, y_s2, y_s3, y_s4, y_s5, y_s6;
	logic signed [CRD_W-1:0] vy_s1, vy_s2, vy_s3, vy_s4, vy_s5, vy_s6;

	assign dsum = cneg_s5 ? bm2_s5 + ac_s5 : bm2_s5 - ac_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		// single 32x32 products
		vxx_s1 <= vel_x * vel_x;
		vzz_s1 <= vel_z * vel_z;
		bx_s1  <= vel_x * pos_x;
		bz_s1  <= vel_z * pos_z;
		xx_s1  <= pos_x * pos_x;
		zz_s1  <= pos_z * pos_z;
		rr_s1  <= radius * radius;
		y_s1   <= pos_y;
		vy_s1  <= vel_y;
		// coefficient sums
		a_s2  <= $unsigned(vxx_s1) + $unsigned(vzz_s1);
		b_s2  <= 65'(bx_s1) + 65'(bz_s1);
		c_s2  <= $signed({1'b0, $unsigned(xx_s1) + $unsigned(zz_s1)}) - $signed({3'b000, rr_s1});
		y_s2  <= y_s1;
		vy_s2 <= vy_s1;
		// magnitudes
		amag_s3  <= a_s2;
		degen_s3 <= (a_s2 == '0);
		bm_s3    <= b_s2[64] ? 64'(-b_s2) : b_s2[63:0];
		cneg_s3  <= c_s2[64];
		cmag_s3  <= c_s2[64] ? 64'(-c_s2) : c_s2[63:0];
		b_s3     <= b_s2;
		y_s3     <= y_s2;
		vy_s3    <= vy_s2;
		// partial products of B^2 and A*|C|
		p00_s4 <= bm_s3[31:0] * bm_s3[31:0];
		p01_s4 <= bm_s3[31:0] * bm_s3[63:32];
		p11_s4 <= bm_s3[63:32] * bm_s3[63:32];
		q00_s4 <= amag_s3[31:0] * cmag_s3[31:0];
		q01_s4 <= amag_s3[31:0] * cmag_s3[63:32];
		q10_s4 <= amag_s3[63:32] * cmag_s3[31:0];
		q11_s4 <= amag_s3[63:32] * cmag_s3[63:32];
		amag_s4  <= amag_s3;
		degen_s4 <= degen_s3;
		cneg_s4  <= cneg_s3;
		b_s4     <= b_s3;
		y_s4     <= y_s3;
		vy_s4    <= vy_s3;
		// combine partials
		bm2_s5 <= {p11_s4, 64'd0} + {31'd0, p01_s4, 33'd0} + {64'd0, p00_s4};
		ac_s5  <= {q11_s4, 64'd0} + {32'd0, q01_s4, 32'd0} + {32'd0, q10_s4, 32'd0}
		        + {64'd0, q00_s4};
		amag_s5  <= amag_s4;
		degen_s5 <= degen_s4;
		cneg_s5  <= cneg_s4;
		b_s5     <= b_s4;
		y_s5     <= y_s4;
		vy_s5    <= vy_s4;
		// discriminant
		disc_s6  <= dsum;
		miss_s6  <= dsum[DISC_W-1];
		amag_s6  <= amag_s5;
		degen_s6 <= degen_s5;
		b_s6     <= b_s5;
		y_s6     <= y_s5;
		vy_s6    <= vy_s5;
	end

	assign out_valid  = v_s6;
	assign disc       = disc_s6;
	assign side.degen = degen_s6;
	assign side.miss  = miss_s6;
	assign side.amag  = amag_s6;
	assign side.b     = b_s6;
	assign side.y     = y_s6;
	assign side.vy    = vy_s6;

endmodule

// ===== rtl/rci_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with sideband.
// Depends on rci_pkg.
module rci_sqrt import rci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DISC_W-1:0] radicand,
	input  side_a_t           in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output side_a_t           out_side
);

	logic [DISC_W-1:0]   rad_s  [SQ_ST];
	logic [SQ_REM_W-1:0] rem_s  [SQ_ST];
	logic [ROOT_W-1:0]   root_s [SQ_ST];
	side_a_t             side_s [SQ_ST];
	logic [SQ_ST-1:0]    v_s;
	logic [DISC_W-1:0]   rad_n  [SQ_ST];
	logic [SQ_REM_W-1:0] rem_n  [SQ_ST];
	logic [ROOT_W-1:0]   root_n [SQ_ST];

	always_comb begin
		logic [DISC_W-1:0]   r;
		logic [SQ_REM_W-1:0] m;
		logic [ROOT_W-1:0]   q;
		logic [SQ_REM_W+1:0] rs, tr;
		for (int j = 0; j < SQ_ST; j++) begin
			if (j == 0) begin
				r = radicand; m = '0; q = '0;
			end else begin
				r = rad_s[j-1]; m = rem_s[j-1]; q = root_s[j-1];
			end
			rs = {m, r[DISC_W-1 -: 2]};
			tr = {2'b00, q, 2'b01};
			if (rs >= tr) begin
				rem_n[j]  = SQ_REM_W'(rs - tr);
				root_n[j] = {q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_n[j]  = SQ_REM_W'(rs);
				root_n[j] = {q[ROOT_W-2:0], 1'b0};
			end
			rad_n[j] = r << 2;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < SQ_ST; j++) begin
			rad_s[j]  <= rad_n[j];
			rem_s[j]  <= rem_n[j];
			root_s[j] <= root_n[j];
			if (j == 0) begin
				side_s[j] <= in_side;
			end else begin
				side_s[j] <= side_s[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[SQ_ST-2:0], in_valid};
		end
	end

	assign out_valid = v_s[SQ_ST-1];
	assign root      = root_s[SQ_ST-1];
	assign out_side  = side_s[SQ_ST-1];

	a_root_align: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(in_valid, SQ_ST))
		else $error("root valid out of step with its request");

endmodule

// ===== rtl/rci_div.sv =====
// Pipelined restoring divider, unsigned, one quotient bit per stage.
// Depends on rci_pkg.
module rci_div import rci_pkg::*; (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	logic [NUM_W-1:0] num_s [DIV_ST];
	logic [DEN_W-1:0] rem_s [DIV_ST];
	logic [QUO_W-1:0] quo_s [DIV_ST];
	logic [DEN_W-1:0] den_s [DIV_ST];
	logic [NUM_W-1:0] num_n [DIV_ST];
	logic [DEN_W-1:0] rem_n [DIV_ST];
	logic [QUO_W-1:0] quo_n [DIV_ST];
	logic [DEN_W-1:0] den_n [DIV_ST];

	always_comb begin
		logic [NUM_W-1:0] n;
		logic [DEN_W-1:0] m, d;
		logic [QUO_W-1:0] q;
		logic [DEN_W:0]   rs;
		for (int j = 0; j < DIV_ST; j++) begin
			if (j == 0) begin
				n = num; m = '0; q = '0; d = den;
			end else begin
				n = num_s[j-1]; m = rem_s[j-1]; q = quo_s[j-1]; d = den_s[j-1];
			end
			rs = {m, n[NUM_W-1]};
			if (rs >= {1'b0, d}) begin
				rem_n[j] = DEN_W'(rs - {1'b0, d});
				quo_n[j] = {q[QUO_W-2:0], 1'b1};
			end else begin
				rem_n[j] = rs[DEN_W-1:0];
				quo_n[j] = {q[QUO_W-2:0], 1'b0};
			end
			num_n[j] = n << 1;
			den_n[j] = d;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < DIV_ST; j++) begin
			num_s[j] <= num_n[j];
			rem_s[j] <= rem_n[j];
			quo_s[j] <= quo_n[j];
			den_s[j] <= den_n[j];
		end
	end

	assign quo = quo_s[DIV_ST-1];

endmodule

// ===== rtl/rci_clip.sv =====
// Back end: saturation, end-plane tests, clipping and the result register.
// Depends on rci_pkg.
module rci_clip import rci_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  side_d_t                  in_side,
	input  logic [QUO_W-1:0]         q_in,
	input  logic [QUO_W-1:0]         q_out,
	input  logic [QUO_W-1:0]         q_top,
	input  logic [QUO_W-1:0]         q_bot,
	input  logic [CFG_W-1:0]         height,
	output logic                     done,
	output status_t                  status,
	output logic signed [TIME_W-1:0] time_in,
	output logic signed [TIME_W-1:0] time_out
);

	localparam int Y_W = 97;

	logic v_s1, v_s2, v_s3, v_s4;
	side_d_t side_s1, side_s2, side_s3;
	logic signed [TIME_W-1:0] tin_s1, tout_s1, ttop_s1, tbot_s1;
	logic signed [TIME_W-1:0] tin_s2, tout_s2, ttop_s2, tbot_s2;
	logic signed [TIME_W-1:0] tin_s3, tout_s3, ttop_s3, tbot_s3;
	logic signed [63:0] plo_in_s2, phi_in_s2, plo_out_s2, phi_out_s2;
	logic signed [Y_W-1:0] yin_s3, yout_s3, y0, hw, nhw;
	logic ain, bin, aout, bout, clip_ok;
	status_t st_n, st_s4;
	logic signed [TIME_W-1:0] tin_n, tout_n, tin_s4, tout_s4;

	assign y0  = Y_W'(side_s2.y) <<< 32;
	assign hw  = $signed({35'd0, height, 31'd0});
	assign nhw = -hw;

	assign ain     = yin_s3 > hw;
	assign bin     = yin_s3 < nhw;
	assign aout    = yout_s3 > hw;
	assign bout    = yout_s3 < nhw;
	assign clip_ok = (side_s3.vy != '0);

	always_comb begin
		st_n = ST_HIT; tin_n = tin_s3; tout_n = tout_s3;
		priority if (side_s3.degen) begin
			st_n = ST_DEGEN; tin_n = '0; tout_n = '0;
		end else if (side_s3.miss || (ain && aout) || (bin && bout)) begin
			// no real root, or both crossings beyond the same end
			st_n = ST_MISS; tin_n = '0; tout_n = '0;
		end else begin
			if (clip_ok && ain) tin_n = ttop_s3;
			if (clip_ok && bin) tin_n = tbot_s3;
			if (clip_ok && aout) tout_n = ttop_s3;
			if (clip_ok && bout) tout_n = tbot_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		tin_s1  <= sat_time(q_in, in_side.neg_in);
		tout_s1 <= sat_time(q_out, in_side.neg_out);
		ttop_s1 <= sat_time(q_top, in_side.neg_top);
		tbot_s1 <= sat_time(q_bot, in_side.neg_bot);
		side_s1 <= in_side;
		// vy times a 64-bit time, split in two halves
		plo_in_s2  <= side_s1.vy * $signed({1'b0, tin_s1[31:0]});
		phi_in_s2  <= side_s1.vy * $signed(tin_s1[63:32]);
		plo_out_s2 <= side_s1.vy * $signed({1'b0, tout_s1[31:0]});
		phi_out_s2 <= side_s1.vy * $signed(tout_s1[63:32]);
		tin_s2  <= tin_s1;  tout_s2 <= tout_s1;
		ttop_s2 <= ttop_s1; tbot_s2 <= tbot_s1;
		side_s2 <= side_s1;
		// axial position at each crossing, Q.56
		yin_s3  <= (Y_W'(phi_in_s2) <<< 32) + Y_W'(plo_in_s2) + y0;
		yout_s3 <= (Y_W'(phi_out_s2) <<< 32) + Y_W'(plo_out_s2) + y0;
		tin_s3  <= tin_s2;  tout_s3 <= tout_s2;
		ttop_s3 <= ttop_s2; tbot_s3 <= tbot_s2;
		side_s3 <= side_s2;
		st_s4   <= st_n;
		tin_s4  <= tin_n;
		tout_s4 <= tout_n;
	end

	assign done     = v_s4;
	assign status   = st_s4;
	assign time_in  = tin_s4;
	assign time_out = tout_s4;

	a_zero_unless_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_HIT) |-> (time_in == '0 && time_out == '0))
		else $error("non-hit result carries a time");

endmodule

// ===== tb/ray_cylinder_intersection_unit_tb.sv =====
// Self-checking testbench for the ray against finite cylinder unit: drives requests
// and register writes, predicts every result and compares it. Depends on rci_pkg.
`timescale 1ns / 100ps

module ray_cylinder_intersection_unit_tb;
	import rci_pkg::*;

	localparam longint CYCLE_LIMIT = 300000;

	typedef struct {
		status_t          status;
		logic [TIME_W-1:0] t_in;
		logic [TIME_W-1:0] t_out;
	} hit_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic signed [CRD_W-1:0]  pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [CRD_W-1:0]  vel_x = '0, vel_y = '0, vel_z = '0;
	logic                     wr_en = 1'b0;
	logic                     wr_index = REG_RADIUS;
	logic [CFG_W-1:0]         wr_data = '0;
	logic                     done;
	logic [1:0]               status;
	logic signed [TIME_W-1:0] time_in, time_out;

	// model copy of the two registers
	logic [CFG_W-1:0] radius_m = RADIUS_RST;
	logic [CFG_W-1:0] height_m = HEIGHT_RST;

	hit_t   pending_hits[$];
	int     mismatches = 0;
	int     requests_sent = 0;
	int     results_seen = 0;
	int     hits_seen = 0;
	int     degen_seen = 0;
	longint cycles = 0;
	bit     allow_gaps = 1'b1;

	ray_cylinder_intersection_unit i_dut (
		.clk, .arst_n, .start, .busy,
		.pos_x, .pos_y, .pos_z, .vel_x, .vel_y, .vel_z,
		.wr_en, .wr_index, .wr_data,
		.done, .status, .time_in, .time_out
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: give up if the run never drains.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_hits.size());
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [127:0] sx(input logic [31:0] v);
		return {{96{v[31]}}, v};
	endfunction

	// floor of the exact square root of a non-negative 128-bit value
	function automatic logic [63:0] floor_root(input logic [127:0] n);
		logic [127:0] res, one_b, trial;
		res = '0;
		one_b = 128'h1 << 126;
		for (int i = 0; i < 64; i++) begin
			trial = res + one_b;
			if (n >= trial) begin
				n = n - trial;
				res = (res >> 1) + one_b;
			end else begin
				res = res >> 1;
			end
			one_b = one_b >> 2;
		end
		return res[63:0];
	endfunction

	// signed num / (+-dmag), truncated toward zero, saturated to 64 bits
	function automatic logic [63:0] div_time(input logic [127:0] num, input bit dneg,
			input logic [63:0] dmag);
		bit           neg;
		logic [127:0] mag, q;
		neg = num[127] ^ dneg;
		mag = num[127] ? -num : num;
		q = mag / {64'b0, dmag};
		if (!neg)
			return (q > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
		return (q > 128'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : -q[63:0];
	endfunction

	// Entry and exit times of one ray; all sums wrap at 128 bits, which keeps
	// the sign-extended products exact.
	function automatic hit_t cylinder_hit(input logic [31:0] px, py, pz, vx, vy, vz);
		hit_t         r;
		logic [127:0] x, y, z, ux, uy, uz, a, b, c, cabs, ac, babs, disc, negb;
		logic [127:0] y0, hw, nhw, yin, yout, top, bot;
		logic [63:0]  amag, root, t_in, t_out, vmag;
		bit           ain, bin, aout, bout;
		r.status = ST_MISS;
		r.t_in = '0;
		r.t_out = '0;
		x = sx(px); y = sx(py); z = sx(pz);
		ux = sx(vx); uy = sx(vy); uz = sx(vz);
		a = ux * ux + uz * uz;
		amag = a[63:0];
		if (amag == 0) begin
			r.status = ST_DEGEN;
			return r;
		end
		b = ux * x + uz * z;
		c = x * x + z * z - {97'b0, radius_m} * {97'b0, radius_m};
		cabs = c[127] ? -c : c;
		ac = {64'b0, amag} * {64'b0, cabs[63:0]};
		if (c[127])
			ac = -ac;
		babs = b[127] ? -b : b;
		disc = {64'b0, babs[63:0]} * {64'b0, babs[63:0]} - ac;
		if (disc[127])
			return r;
		root = floor_root(disc);
		negb = -b;
		t_in = div_time((negb - {64'b0, root}) << 32, 1'b0, amag);
		t_out = div_time((negb + {64'b0, root}) << 32, 1'b0, amag);
		y0 = y << 32;
		hw = {97'b0, height_m} << 31;
		nhw = -hw;
		yin = uy * sx(32'(0)) + uy * {{64{t_in[63]}}, t_in} + y0;
		yout = uy * {{64{t_out[63]}}, t_out} + y0;
		ain = $signed(hw) < $signed(yin);
		bin = $signed(yin) < $signed(nhw);
		aout = $signed(hw) < $signed(yout);
		bout = $signed(yout) < $signed(nhw);
		// wholly above or wholly below the ends
		if ((ain && aout) || (bin && bout))
			return r;
		if (vy != 0) begin
			vmag = vy[31] ? -uy[63:0] : uy[63:0];
			top = hw - y0;
			bot = nhw - y0;
			if (ain) t_in = div_time(top, vy[31], vmag);
			if (bin) t_in = div_time(bot, vy[31], vmag);
			if (aout) t_out = div_time(top, vy[31], vmag);
			if (bout) t_out = div_time(bot, vy[31], vmag);
		end
		r.status = ST_HIT;
		r.t_in = t_in;
		r.t_out = t_out;
		return r;
	endfunction

	// Result checker: the receiver cannot stall, so take every strobe as it comes.
	always @(posedge clk) begin
		hit_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_hits.size() == 0) begin
				$error("result with no request outstanding: status %0d", status);
				mismatches++;
			end else begin
				want = pending_hits.pop_front();
				if (status != want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (time_in != want.t_in) begin
					$error("time_in: expected %0h, got %0h", want.t_in, time_in);
					mismatches++;
				end
				if (time_out != want.t_out) begin
					$error("time_out: expected %0h, got %0h", want.t_out, time_out);
					mismatches++;
				end
				if (want.status == ST_HIT) hits_seen++;
				if (want.status == ST_DEGEN) degen_seen++;
			end
		end
	end

	// Present one request and hold it until taken; start stays high on return.
	task automatic send_ray(input logic [31:0] px, py, pz, vx, vy, vz);
		start <= 1'b1;
		pos_x <= px; pos_y <= py; pos_z <= pz;
		vel_x <= vx; vel_y <= vy; vel_z <= vz;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_hits.push_back(cylinder_hit(px, py, pz, vx, vy, vz));
		requests_sent++;
	endtask

	// Drop start for a random burst now and then.
	task automatic maybe_gap();
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0)
			@(posedge clk);
	endtask

	// Write one register; only called with the pipeline empty. Drop the
	// enable again after the write, so back-to-back writes stay apart.
	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		if (idx == REG_RADIUS)
			radius_m = value;
		else
			height_m = value;
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Ray aimed roughly at the cylinder, so that most of them hit or clip.
	task automatic send_aimed();
		logic signed [31:0] px, py, pz, vx, vy, vz;
		px = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		py = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		pz = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		vx = -(px >>> 8) + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
		vz = -(pz >>> 8) + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
		vy = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		if ($urandom_range(0, 9) == 0) vy = 0;
		if ($urandom_range(0, 19) == 0) begin
			vx = 0;
			vz = 0;
		end
		send_ray(px, py, pz, vx, vy, vz);
	endtask

	task automatic send_noise();
		send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Field extremes and each named special case.
	task automatic test_directed();
		localparam logic [31:0] ONE_M = 32'h0100_0000;  // 1.0 in Q8.24
		localparam logic [31:0] ONE_V = 32'h0001_0000;  // 1.0 in Q16.16
		localparam logic [31:0] MINV = 32'h8000_0000;
		localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
		send_ray(-2 * ONE_M, 0, 0, ONE_V, 0, 0);            // straight through, no axial speed
		send_ray(-2 * ONE_M, 0, 0, ONE_V, ONE_V >> 2, 0);   // crosses the side, exit clipped at the top plane
		send_ray(-2 * ONE_M, 0, 0, ONE_V, ONE_V, 0);        // both crossings above the top, a miss
		send_ray(-2 * ONE_M, 0, 0, ONE_V, -ONE_V, 0);       // both crossings below the bottom, a miss
		send_ray(0, 0, 0, ONE_V, 4 * ONE_V, ONE_V);         // from inside, steep
		send_ray(-2 * ONE_M, 3 * ONE_M, 0, ONE_V, 0, 0);    // wholly above
		send_ray(-2 * ONE_M, -3 * ONE_M, 0, ONE_V, 0, 0);   // wholly below
		send_ray(-2 * ONE_M, 2 * ONE_M, 0, ONE_V, -ONE_V, 0); // enters through the top
		send_ray(-2 * ONE_M, 2 * ONE_M, 0, 0, ONE_V, 0);    // zero radial speed
		send_ray(0, 0, 0, 0, 0, 0);                         // all zero
		send_ray(-2 * ONE_M, 0, 2 * ONE_M, ONE_V, 0, 0);    // negative discriminant
		send_ray(-2 * ONE_M, 0, ONE_M, ONE_V, 0, 0);        // grazing tangent
		send_ray(MINV, MINV, MINV, MINV, MINV, MINV);
		send_ray(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
		send_ray(MINV, MAXV, MINV, MAXV, MINV, MAXV);
		send_ray(MAXV, 0, MINV, 1, 1, 0);                   // tiny speed, negative discriminant
		send_ray(MINV, 0, 0, MAXV, 1, 32'hFFFF_FFFF);
		send_ray(1, 0, 32'hFFFF_FFFF, MINV, 0, MINV);
		drain();
	endtask

	// Sweep radius and height through extremes, a few rays per setting.
	task automatic test_register_sweep();
		logic [CFG_W-1:0] settings[6] = '{31'd0, 31'h7FFF_FFFF, 31'h0100_0000,
			31'h0000_0001, 31'h0040_0000, 31'h0300_0000};
		foreach (settings[i]) begin
			write_reg(REG_RADIUS, settings[i]);
			write_reg(REG_HEIGHT, settings[(i + 2) % 6]);
			repeat (6) begin
				send_aimed();
				maybe_gap();
			end
			send_noise();
			drain();
		end
	endtask

	// Mostly aimed rays with random content, some noise, across random settings.
	task automatic test_random_rays();
		for (int phase = 0; phase < 8; phase++) begin
			write_reg(REG_RADIUS, CFG_W'($urandom_range(0, 32'h0400_0000)));
			write_reg(REG_HEIGHT, CFG_W'($urandom_range(0, 32'h0800_0000)));
			if (phase == 7)
				allow_gaps = 1'b0;
			repeat (45) begin
				if ($urandom_range(0, 9) < 7)
					send_aimed();
				else
					send_noise();
				maybe_gap();
			end
			drain();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_sweep();
		test_random_rays();
		repeat (LATENCY + 20) @(posedge clk);
		$display("%0d rays sent, %0d results checked: %0d hits, %0d degenerate",
			requests_sent, results_seen, hits_seen, degen_seen);
		$display("register settings swept through zero, one and full scale");
		if (mismatches == 0 && pending_hits.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
